// ----- sv/stm_pkg.sv -----
// Shared types and codes for the stack token machine.
`timescale 1ns / 1ps

package stm_pkg;

    // Stack entry tags
    localparam int TAG_W = 2;
    localparam logic [TAG_W-1:0] TAG_NUM = 2'd0;
    localparam logic [TAG_W-1:0] TAG_VAR = 2'd1;
    localparam logic [TAG_W-1:0] TAG_ARR = 2'd2;

    // Token commands
    localparam logic [4:0] CMD_LIT    = 5'd0;
    localparam logic [4:0] CMD_VREF   = 5'd1;
    localparam logic [4:0] CMD_AREF   = 5'd2;
    localparam logic [4:0] CMD_ADD    = 5'd3;
    localparam logic [4:0] CMD_SUB    = 5'd4;
    localparam logic [4:0] CMD_MUL    = 5'd5;
    localparam logic [4:0] CMD_DIV    = 5'd6;
    localparam logic [4:0] CMD_MOD    = 5'd7;
    localparam logic [4:0] CMD_ASSIGN = 5'd8;
    localparam logic [4:0] CMD_GT     = 5'd9;
    localparam logic [4:0] CMD_LT     = 5'd10;
    localparam logic [4:0] CMD_GE     = 5'd11;
    localparam logic [4:0] CMD_LE     = 5'd12;
    localparam logic [4:0] CMD_EQ     = 5'd13;
    localparam logic [4:0] CMD_NE     = 5'd14;
    localparam logic [4:0] CMD_SHL    = 5'd15;
    localparam logic [4:0] CMD_SHR    = 5'd16;
    localparam logic [4:0] CMD_BAND   = 5'd17;
    localparam logic [4:0] CMD_LAND   = 5'd18;
    localparam logic [4:0] CMD_BOR    = 5'd19;
    localparam logic [4:0] CMD_LOR    = 5'd20;
    localparam logic [4:0] CMD_BNOT   = 5'd21;
    localparam logic [4:0] CMD_LNOT   = 5'd22;
    localparam logic [4:0] CMD_INDEX  = 5'd23;
    localparam logic [4:0] CMD_PRINT  = 5'd24;
    localparam logic [4:0] CMD_IF     = 5'd25;
    localparam logic [4:0] CMD_ELSE   = 5'd26;
    localparam logic [4:0] CMD_END    = 5'd27;
    localparam logic [4:0] CMD_WHILE  = 5'd28;
    localparam logic [4:0] CMD_DO     = 5'd29;
    localparam logic [4:0] CMD_ALLOC  = 5'd30;

    // Error codes
    localparam logic [3:0] ERR_OK     = 4'd0;
    localparam logic [3:0] ERR_UNDER  = 4'd1;
    localparam logic [3:0] ERR_KIND   = 4'd2;
    localparam logic [3:0] ERR_RANGE  = 4'd3;
    localparam logic [3:0] ERR_DALLOC = 4'd4;
    localparam logic [3:0] ERR_HEAP   = 4'd5;
    localparam logic [3:0] ERR_OVF    = 4'd6;
    localparam logic [3:0] ERR_DZERO  = 4'd7;
    localparam logic [3:0] ERR_HALT   = 4'd8;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic signed [15:0] dividend;
        logic signed [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
        logic [15:0] rem;
    } t_div_rsp;

endpackage

// ----- sv/stm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module stm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/stm_div.sv -----
// Iterative signed 16-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module stm_div
    import stm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic [15:0] r_dvs;
    logic        r_qneg;
    logic        r_rneg;

    logic [16:0] trial;
    logic [16:0] diff;
    logic [15:0] abs_a;
    logic [15:0] abs_b;

    // magnitudes; the most negative value maps to 0x8000
    assign abs_a = i_req.dividend[15] ? 16'(-i_req.dividend) : i_req.dividend;
    assign abs_b = i_req.divisor[15]  ? 16'(-i_req.divisor)  : i_req.divisor;

    // restoring step
    assign trial = {r_rem, r_quo[15]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= abs_a;
            r_dvs  <= abs_b;
            r_qneg <= i_req.dividend[15] ^ i_req.divisor[15];
            r_rneg <= i_req.dividend[15];
        end else if (r_busy) begin
            if (!diff[16]) begin
                r_rem <= diff[15:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= trial[15:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    // sign correction: quotient truncates toward zero, remainder follows dividend
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_qneg ? 16'(-r_quo) : r_quo;
    assign o_rsp.rem  = r_rneg ? 16'(-r_rem) : r_rem;

endmodule

// ----- sv/stm_alu.sv -----
// Combinational 16-bit ALU for arithmetic, compare, shift and logic tokens.
`timescale 1ns / 1ps

module stm_alu
    import stm_pkg::*;
(
    input  logic [4:0]         i_op,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    output logic [15:0]        o_result
);

    logic [15:0] prod;
    logic [4:0]  shamt;
    logic [15:0] shl;
    logic [15:0] shr;
    logic [31:0] ext;

    assign prod  = i_a * i_b;
    // out-of-range shift amounts act as 16
    assign shamt = (i_b < 16'sd0 || i_b > 16'sd31) ? 5'd16 : i_b[4:0];
    assign shl   = 16'({16'b0, i_a} << shamt);
    assign ext   = {{16{i_a[15]}}, i_a};
    assign shr   = 16'($signed(ext) >>> shamt);

    always_comb begin
        unique case (i_op)
            CMD_ADD:  o_result = i_a + i_b;
            CMD_SUB:  o_result = i_a - i_b;
            CMD_MUL:  o_result = prod;
            CMD_GT:   o_result = {15'b0, i_a > i_b};
            CMD_LT:   o_result = {15'b0, i_a < i_b};
            CMD_GE:   o_result = {15'b0, i_a >= i_b};
            CMD_LE:   o_result = {15'b0, i_a <= i_b};
            CMD_EQ:   o_result = {15'b0, i_a == i_b};
            CMD_NE:   o_result = {15'b0, i_a != i_b};
            CMD_SHL:  o_result = shl;
            CMD_SHR:  o_result = shr;
            CMD_BAND: o_result = i_a & i_b;
            CMD_LAND: o_result = {15'b0, (i_a != 16'sd0) && (i_b != 16'sd0)};
            CMD_BOR:  o_result = i_a | i_b;
            CMD_LOR:  o_result = {15'b0, (i_a != 16'sd0) || (i_b != 16'sd0)};
            CMD_BNOT: o_result = ~i_a;
            default:  o_result = {15'b0, i_a == 16'sd0};
        endcase
    end

endmodule

// ----- sv/stack_token_machine.sv -----
// Top level of the stack token machine: sequencer, stack and data memories.
`timescale 1ns / 1ps

// Executes one token of a 16-bit stack language per request and returns one
// result per request. After reset the data memory is swept to zero, one word a
// cycle, all NUM_VARS + HEAP_WORDS words (33792 with the defaults), while input
// requests are stalled. Then a push token is executed straight away; every other
// token first reads the two top stack entries and dereferences variables, one
// after another through the single read port of each memory, and divide or modulo
// then wait for the 16-step divider. A request that arrives while halted goes
// straight to its result. The next request is taken once the result is passed on.
// Any error halts the block until reset; later requests answer with the halted
// code.
module stack_token_machine
    import stm_pkg::*;
#(
    parameter int STACK_DEPTH = 128,
    parameter int NUM_VARS    = 1024,
    parameter int HEAP_WORDS  = 32768,
    parameter int NUM_ARRAYS  = 26
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [4:0]         i_command,
    input  logic signed [15:0] i_literal,
    input  logic [9:0]         i_var_address,
    input  logic [4:0]         i_array_slot,
    input  logic [15:0]        i_jump_target,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_print_valid,
    output logic signed [15:0] o_print_value,
    output logic               o_branch_taken,
    output logic [15:0]        o_branch_target,
    output logic [3:0]         o_error_code
);

    localparam int MEM_WORDS = NUM_VARS + HEAP_WORDS;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int VAL_W     = (MEM_AW > 16) ? MEM_AW : 16;
    localparam int ENT_W     = TAG_W + VAL_W;
    localparam int SP_AW     = $clog2(STACK_DEPTH);
    localparam int SP_W      = SP_AW + 1;
    localparam int SLOT_W    = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
    localparam int HP_W      = $clog2(HEAP_WORDS + 1);
    localparam int SUM_W     = ((HP_W > 16) ? HP_W : 16) + 1;
    localparam int IDX_W     = MEM_AW + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HI    = 3'd2;
    localparam logic [2:0] S_LO    = 3'd3;
    localparam logic [2:0] S_LV    = 3'd4;
    localparam logic [2:0] S_EXEC  = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // reduce a variable address by repeated shifted subtraction
    function automatic logic [9:0] var_mod(input logic [9:0] x);
        logic [23:0] v;
        v = 24'(x);
        for (int k = 6; k >= 0; k--) begin
            if (v >= (24'(NUM_VARS) << k)) begin
                v = v - (24'(NUM_VARS) << k);
            end
        end
        return v[9:0];
    endfunction

    function automatic logic [4:0] slot_mod(input logic [4:0] x);
        logic [11:0] v;
        v = 12'(x);
        for (int k = 5; k >= 0; k--) begin
            if (v >= (12'(NUM_ARRAYS) << k)) begin
                v = v - (12'(NUM_ARRAYS) << k);
            end
        end
        return v[4:0];
    endfunction

    logic [2:0]        r_state;
    logic [MEM_AW-1:0] r_clr;
    logic [SP_W-1:0]   r_sp;
    logic [HP_W-1:0]   r_hp;
    logic              r_halted;
    logic [4:0]        r_cmd;
    logic [ENT_W-1:0]  r_push;
    logic [15:0]       r_tgt;
    logic [ENT_W-1:0]  r_hi;
    logic [ENT_W-1:0]  r_lo;
    logic [15:0]       r_hv;
    logic [15:0]       r_lv;

    logic              r_arr_valid [NUM_ARRAYS];
    logic [HP_W-1:0]   r_arr_base  [NUM_ARRAYS];
    logic [14:0]       r_arr_len   [NUM_ARRAYS];

    logic              r_res_pv;
    logic [15:0]       r_res_pval;
    logic              r_res_bt;
    logic [15:0]       r_res_btgt;
    logic [3:0]        r_res_err;

    logic              r_out_valid;
    logic              r_out_pv;
    logic [15:0]       r_out_pval;
    logic              r_out_bt;
    logic [15:0]       r_out_btgt;
    logic [3:0]        r_out_err;

    logic              accept;
    logic [SP_W-1:0]   spm1;
    logic [SP_W-1:0]   spm2;
    logic [ENT_W-1:0]  stk_rdata;
    logic [SP_AW-1:0]  stk_raddr;
    logic              stk_we;
    logic [SP_AW-1:0]  stk_waddr;
    logic [ENT_W-1:0]  stk_wdata;
    logic [15:0]       mem_rdata;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ENT_W-1:0]  push_ent;
    logic [4:0]        push_slot;
    logic [9:0]        push_var;
    logic [15:0]       alu_a;
    logic [15:0]       alu_res;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic [TAG_W-1:0]  hi_tag;
    logic [TAG_W-1:0]  lo_tag;
    logic              hnum;
    logic              lnum;
    logic              is_push;
    logic              is_unary;
    logic              is_bin;
    logic [SLOT_W-1:0] slot_idx;
    logic              slot_ok;
    logic              d_valid;
    logic [HP_W-1:0]   d_base;
    logic [14:0]       d_len;
    logic [IDX_W-1:0]  idx_addr;
    logic [SUM_W-1:0]  heap_sum;

    logic              ex_err_set;
    logic [3:0]        ex_err;
    logic              ex_stk_we;
    logic [SP_AW-1:0]  ex_stk_addr;
    logic [ENT_W-1:0]  ex_stk_data;
    logic              ex_mem_we;
    logic [SP_W-1:0]   ex_sp;
    logic [HP_W-1:0]   ex_hp;
    logic              ex_arr_we;
    logic              ex_pv;
    logic              ex_bt;
    logic              ex_div;
    logic [15:0]       div_result;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign spm1       = r_sp - SP_W'(1);
    assign spm2       = r_sp - SP_W'(2);

    // operand stack and data memory
    stm_ram #(.WIDTH(ENT_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    stm_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_data (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (stk_rdata[MEM_AW-1:0]),
        .o_rdata (mem_rdata)
    );

    stm_alu u_alu (
        .i_op     (r_cmd),
        .i_a      (alu_a),
        .i_b      (r_hv),
        .o_result (alu_res)
    );

    stm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // top entry first, then the one below it
    assign stk_raddr = (r_state == S_IDLE) ? spm1[SP_AW-1:0] : spm2[SP_AW-1:0];

    // entry pushed by a reference or literal token
    assign push_var  = var_mod(i_var_address);
    assign push_slot = slot_mod(i_array_slot);
    always_comb begin
        priority if (i_command == CMD_LIT) begin
            push_ent = {TAG_NUM, VAL_W'(i_literal)};
        end else if (i_command == CMD_VREF) begin
            push_ent = {TAG_VAR, VAL_W'(push_var)};
        end else begin
            push_ent = {TAG_ARR, VAL_W'(push_slot)};
        end
    end

    // operand decode
    assign hi_tag   = r_hi[ENT_W-1 -: TAG_W];
    assign lo_tag   = r_lo[ENT_W-1 -: TAG_W];
    assign hnum     = (hi_tag == TAG_NUM) || (hi_tag == TAG_VAR);
    assign lnum     = (lo_tag == TAG_NUM) || (lo_tag == TAG_VAR);
    assign is_push  = (r_cmd == CMD_LIT) || (r_cmd == CMD_VREF) || (r_cmd == CMD_AREF);
    assign is_unary = (r_cmd == CMD_BNOT) || (r_cmd == CMD_LNOT);
    assign is_bin   = ((r_cmd >= CMD_ADD) && (r_cmd <= CMD_INDEX)) || (r_cmd == CMD_ALLOC);
    assign alu_a    = is_unary ? r_hv : r_lv;

    // array descriptor of the lower operand
    assign slot_idx = r_lo[SLOT_W-1:0];
    assign slot_ok  = (32'(slot_idx) < NUM_ARRAYS);
    assign d_valid  = slot_ok ? r_arr_valid[slot_idx] : 1'b0;
    assign d_base   = slot_ok ? r_arr_base[slot_idx]  : '0;
    assign d_len    = slot_ok ? r_arr_len[slot_idx]   : '0;
    assign idx_addr = IDX_W'(NUM_VARS) + IDX_W'(d_base) + IDX_W'(r_hv[14:0]);
    assign heap_sum = SUM_W'(r_hp) + SUM_W'(r_hv[14:0]);

    // token execution; state changes only on the success paths
    always_comb begin
        ex_err_set  = 1'b0;
        ex_err      = ERR_OK;
        ex_stk_we   = 1'b0;
        ex_stk_addr = spm2[SP_AW-1:0];
        ex_stk_data = {TAG_NUM, VAL_W'(alu_res)};
        ex_mem_we   = 1'b0;
        ex_sp       = r_sp;
        ex_hp       = r_hp;
        ex_arr_we   = 1'b0;
        ex_pv       = 1'b0;
        ex_bt       = 1'b0;
        ex_div      = 1'b0;
        priority if (is_push) begin
            if (r_sp >= SP_W'(STACK_DEPTH)) begin
                ex_err_set = 1'b1;
                ex_err     = ERR_OVF;
            end else begin
                ex_stk_we   = 1'b1;
                ex_stk_addr = r_sp[SP_AW-1:0];
                ex_stk_data = r_push;
                ex_sp       = r_sp + SP_W'(1);
            end
        end else if (is_unary) begin
            if (r_sp < SP_W'(1)) begin
                ex_err_set = 1'b1;
                ex_err     = ERR_UNDER;
            end else if (!hnum) begin
                ex_err_set = 1'b1;
                ex_err     = ERR_KIND;
            end else begin
                ex_stk_we   = 1'b1;
                ex_stk_addr = spm1[SP_AW-1:0];
            end
        end else if (is_bin) begin
            if (r_sp < SP_W'(2)) begin
                ex_err_set = 1'b1;
                ex_err     = ERR_UNDER;
            end else if (r_cmd == CMD_ASSIGN) begin
                if (!lnum || hi_tag != TAG_VAR) begin
                    ex_err_set = 1'b1;
                    ex_err     = ERR_KIND;
                end else begin
                    ex_mem_we = 1'b1;
                    ex_sp     = spm2;
                end
            end else if (r_cmd == CMD_INDEX || r_cmd == CMD_ALLOC) begin
                if (lo_tag != TAG_ARR) begin
                    ex_err_set = 1'b1;
                    ex_err     = ERR_KIND;
                end else if (r_cmd == CMD_ALLOC && d_valid) begin
                    ex_err_set = 1'b1;
                    ex_err     = ERR_DALLOC;
                end else if (!hnum) begin
                    ex_err_set = 1'b1;
                    ex_err     = ERR_KIND;
                end else if (r_cmd == CMD_INDEX) begin
                    if (r_hv[15] || r_hv[14:0] >= d_len) begin
                        ex_err_set = 1'b1;
                        ex_err     = ERR_RANGE;
                    end else begin
                        ex_stk_we   = 1'b1;
                        ex_stk_data = {TAG_VAR, VAL_W'(idx_addr[MEM_AW-1:0])};
                        ex_sp       = spm1;
                    end
                end else if (r_hv[15] || heap_sum > SUM_W'(HEAP_WORDS)) begin
                    ex_err_set = 1'b1;
                    ex_err     = ERR_HEAP;
                end else begin
                    ex_arr_we = 1'b1;
                    ex_hp     = HP_W'(heap_sum);
                    ex_sp     = spm2;
                end
            end else if (!lnum || !hnum) begin
                ex_err_set = 1'b1;
                ex_err     = ERR_KIND;
            end else if ((r_cmd == CMD_DIV || r_cmd == CMD_MOD) && r_hv == 16'd0) begin
                ex_err_set = 1'b1;
                ex_err     = ERR_DZERO;
            end else if (r_cmd == CMD_DIV || r_cmd == CMD_MOD) begin
                ex_div = 1'b1;
            end else begin
                ex_stk_we = 1'b1;
                ex_sp     = spm1;
            end
        end else if (r_cmd == CMD_PRINT || r_cmd == CMD_IF || r_cmd == CMD_DO) begin
            if (r_sp < SP_W'(1)) begin
                ex_err_set = 1'b1;
                ex_err     = ERR_UNDER;
            end else begin
                ex_sp = spm1;
                if (hnum) begin
                    ex_pv = (r_cmd == CMD_PRINT);
                    ex_bt = (r_cmd != CMD_PRINT) && (r_hv == 16'd0);
                end
            end
        end else if (r_cmd == CMD_ELSE) begin
            ex_bt = 1'b1;
        end else if (r_cmd == CMD_END) begin
            ex_bt = (r_tgt != 16'd0);
        end else if (r_cmd == CMD_WHILE) begin
            ex_bt = 1'b0;
        end else begin
            ex_err_set = 1'b1;
            ex_err     = ERR_KIND;
        end
    end

    assign div_req.start    = (r_state == S_EXEC) && ex_div;
    assign div_req.dividend = r_lv;
    assign div_req.divisor  = r_hv;
    assign div_result       = (r_cmd == CMD_DIV) ? div_rsp.quot : div_rsp.rem;

    // stack write port
    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = ex_stk_addr;
        stk_wdata = ex_stk_data;
        if (r_state == S_EXEC) begin
            stk_we = ex_stk_we;
        end else if (r_state == S_DIV) begin
            stk_we    = div_rsp.done;
            stk_waddr = spm2[SP_AW-1:0];
            stk_wdata = {TAG_NUM, VAL_W'(div_result)};
        end
    end

    // data memory write port: clearing sweep or assignment
    assign mem_we    = (r_state == S_CLEAR) || ((r_state == S_EXEC) && ex_mem_we);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : r_hi[MEM_AW-1:0];
    assign mem_wdata = (r_state == S_CLEAR) ? 16'd0 : r_lv;

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_sp     <= '0;
            r_hp     <= '0;
            r_halted <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + MEM_AW'(1);
                    if (r_clr == MEM_AW'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (r_halted) begin
                            r_state <= S_DONE;
                        end else if (i_command == CMD_LIT || i_command == CMD_VREF
                                     || i_command == CMD_AREF) begin
                            r_state <= S_EXEC;
                        end else begin
                            r_state <= S_HI;
                        end
                    end
                end
                S_HI:   r_state <= S_LO;
                S_LO:   r_state <= S_LV;
                S_LV:   r_state <= S_EXEC;
                S_EXEC: begin
                    if (ex_err_set) begin
                        r_halted <= 1'b1;
                        r_state  <= S_DONE;
                    end else if (ex_div) begin
                        r_state <= S_DIV;
                    end else begin
                        r_sp    <= ex_sp;
                        r_hp    <= ex_hp;
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_sp    <= spm1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request and operand registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_push <= push_ent;
            r_tgt  <= i_jump_target;
        end
        if (r_state == S_HI) begin
            r_hi <= stk_rdata;
        end
        if (r_state == S_LO) begin
            r_lo <= stk_rdata;
            r_hv <= (hi_tag == TAG_VAR) ? mem_rdata : r_hi[15:0];
        end
        if (r_state == S_LV) begin
            r_lv <= (stk_rdata[ENT_W-1 -: TAG_W] == TAG_VAR || lo_tag == TAG_VAR)
                    && lo_tag == TAG_VAR ? mem_rdata : r_lo[15:0];
        end
    end

    // array descriptor table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ARRAYS; i++) begin
                r_arr_valid[i] <= 1'b0;
                r_arr_base[i]  <= '0;
                r_arr_len[i]   <= '0;
            end
        end else if (r_state == S_EXEC && ex_arr_we && !ex_err_set) begin
            r_arr_valid[slot_idx] <= 1'b1;
            r_arr_base[slot_idx]  <= r_hp;
            r_arr_len[slot_idx]   <= r_hv[14:0];
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (accept && r_halted) begin
            r_res_pv   <= 1'b0;
            r_res_pval <= '0;
            r_res_bt   <= 1'b0;
            r_res_btgt <= '0;
            r_res_err  <= ERR_HALT;
        end else if (r_state == S_EXEC) begin
            r_res_pv   <= ex_pv && !ex_err_set;
            r_res_pval <= (ex_pv && !ex_err_set) ? r_hv : 16'd0;
            r_res_bt   <= ex_bt && !ex_err_set;
            r_res_btgt <= (ex_bt && !ex_err_set) ? r_tgt : 16'd0;
            r_res_err  <= ex_err;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_pv   <= r_res_pv;
            r_out_pval <= r_res_pval;
            r_out_bt   <= r_res_bt;
            r_out_btgt <= r_res_btgt;
            r_out_err  <= r_res_err;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_print_valid   = r_out_pv;
    assign o_print_value   = r_out_pval;
    assign o_branch_taken  = r_out_bt;
    assign o_branch_target = r_out_btgt;
    assign o_error_code    = r_out_err;

`ifndef SYNTH
    // the stack pointer never passes the stack depth
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer out of range");

    // the heap pointer never passes the heap size
    a_hp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_hp) <= SUM_W'(HEAP_WORDS))
        else $error("heap pointer out of range");

    // an error in execution halts the block
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && ex_err_set) |=> r_halted)
        else $error("error did not halt");

    // a halted block writes no memory outside the clearing sweep
    a_halt_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && r_state != S_CLEAR) |-> (!stk_we && !mem_we))
        else $error("write while halted");

    // a divide start leaves the sequencer waiting on the divider
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_state == S_DIV))
        else $error("divider started outside wait");
`endif

endmodule

// ----- dv/stack_token_machine_tb.sv -----
// Testbench for the stack token machine: directed and random token streams checked against a scoreboard.
`timescale 1ns / 1ps

module stack_token_machine_tb;
    import stm_pkg::*;

    localparam int NVARS     = 1024;
    localparam int NHEAP     = 32768;
    localparam int NSLOTS    = 26;
    localparam int SDEPTH    = 128;
    localparam int MEMW      = NVARS + NHEAP;
    localparam int RAND_REQS = 1200;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [15:0] lit;
        logic [9:0]  vaddr;
        logic [4:0]  slot;
        logic [15:0] target;
    } token_t;

    typedef struct packed {
        logic        pvalid;
        logic [15:0] pvalue;
        logic        taken;
        logic [15:0] btarget;
        logic [3:0]  err;
    } outcome_t;

    // Token machine predictor plus queue of pending outcomes
    class token_scoreboard;
        logic [1:0]  tag[SDEPTH];
        int          val[SDEPTH];
        logic [15:0] mem[MEMW];
        bit          slot_used[NSLOTS];
        int          slot_base[NSLOTS];
        int          slot_len[NSLOTS];
        int          sp;
        int          hp;
        bit          halted;
        outcome_t    pending[$];
        int          mismatches;

        function new();
            foreach (mem[i]) mem[i] = '0;
            foreach (slot_used[i]) begin
                slot_used[i] = 0;
                slot_base[i] = 0;
                slot_len[i]  = 0;
            end
            sp = 0;
            hp = 0;
            halted = 0;
            mismatches = 0;
        endfunction

        function int sx(int x);
            logic signed [15:0] t;
            t = x[15:0];
            return t;
        endfunction

        // Operand value of a stack entry; word refs are dereferenced
        function bit numeric(int idx, output int v);
            v = 0;
            if (tag[idx] == TAG_NUM) begin
                v = sx(val[idx]);
                return 1;
            end
            if (tag[idx] == TAG_VAR) begin
                v = sx(mem[val[idx]]);
                return 1;
            end
            return 0;
        endfunction

        function int alu(logic [4:0] cmd, int a, int b);
            int n;
            int r;
            n = (b < 0 || b > 31) ? 16 : b;
            case (cmd)
                CMD_ADD:  r = a + b;
                CMD_SUB:  r = a - b;
                CMD_MUL:  r = a * b;
                CMD_DIV:  r = a / b;
                CMD_MOD:  r = a % b;
                CMD_GT:   r = a > b;
                CMD_LT:   r = a < b;
                CMD_GE:   r = a >= b;
                CMD_LE:   r = a <= b;
                CMD_EQ:   r = a == b;
                CMD_NE:   r = a != b;
                CMD_SHL:  r = a << n;
                CMD_SHR:  r = a >>> n;
                CMD_BAND: r = a & b;
                CMD_LAND: r = (a != 0) && (b != 0);
                CMD_BOR:  r = a | b;
                CMD_LOR:  r = (a != 0) || (b != 0);
                CMD_BNOT: r = ~a;
                default:  r = (a == 0);
            endcase
            return r & 32'hFFFF;
        endfunction

        // Executes one token; state only changes when commit is set
        function logic [3:0] exec(token_t t, bit commit, output outcome_t r);
            int a;
            int b;
            int lo;
            int hi;
            int s;
            r = '0;
            lo = sp - 2;
            hi = sp - 1;
            case (t.cmd)
                CMD_LIT, CMD_VREF, CMD_AREF: begin
                    if (sp >= SDEPTH) return ERR_OVF;
                    if (commit) begin
                        tag[sp] = (t.cmd == CMD_LIT) ? TAG_NUM :
                                  (t.cmd == CMD_VREF) ? TAG_VAR : TAG_ARR;
                        val[sp] = (t.cmd == CMD_LIT) ? int'(t.lit) :
                                  (t.cmd == CMD_VREF) ? int'(t.vaddr) % NVARS :
                                  int'(t.slot) % NSLOTS;
                        sp++;
                    end
                end
                CMD_BNOT, CMD_LNOT: begin
                    if (sp < 1) return ERR_UNDER;
                    if (!numeric(hi, a)) return ERR_KIND;
                    if (commit) begin
                        tag[hi] = TAG_NUM;
                        val[hi] = alu(t.cmd, a, 0);
                    end
                end
                CMD_ASSIGN: begin
                    if (sp < 2) return ERR_UNDER;
                    if (!numeric(lo, a) || tag[hi] != TAG_VAR) return ERR_KIND;
                    if (commit) begin
                        mem[val[hi]] = a[15:0];
                        sp -= 2;
                    end
                end
                CMD_INDEX, CMD_ALLOC: begin
                    if (sp < 2) return ERR_UNDER;
                    if (tag[lo] != TAG_ARR) return ERR_KIND;
                    s = val[lo];
                    if (t.cmd == CMD_ALLOC && slot_used[s]) return ERR_DALLOC;
                    if (!numeric(hi, b)) return ERR_KIND;
                    if (t.cmd == CMD_INDEX) begin
                        if (b < 0 || b >= slot_len[s]) return ERR_RANGE;
                        if (commit) begin
                            tag[lo] = TAG_VAR;
                            val[lo] = NVARS + slot_base[s] + b;
                            sp--;
                        end
                    end else begin
                        if (b < 0 || hp + b > NHEAP) return ERR_HEAP;
                        if (commit) begin
                            slot_used[s] = 1;
                            slot_base[s] = hp;
                            slot_len[s]  = b;
                            hp += b;
                            sp -= 2;
                        end
                    end
                end
                CMD_PRINT, CMD_IF, CMD_DO: begin
                    if (sp < 1) return ERR_UNDER;
                    if (numeric(hi, a)) begin
                        if (t.cmd == CMD_PRINT) begin
                            r.pvalid = 1;
                            r.pvalue = a[15:0];
                        end else if (a == 0) begin
                            r.taken   = 1;
                            r.btarget = t.target;
                        end
                    end
                    if (commit) sp--;
                end
                CMD_ELSE: begin
                    r.taken   = 1;
                    r.btarget = t.target;
                end
                CMD_END: begin
                    if (t.target != 0) begin
                        r.taken   = 1;
                        r.btarget = t.target;
                    end
                end
                CMD_WHILE: ;
                default: begin
                    // binary arithmetic, comparison, shift and logic operators
                    if (t.cmd < CMD_ADD || t.cmd > CMD_LOR) return ERR_KIND;
                    if (sp < 2) return ERR_UNDER;
                    if (!numeric(lo, a) || !numeric(hi, b)) return ERR_KIND;
                    if ((t.cmd == CMD_DIV || t.cmd == CMD_MOD) && b == 0) return ERR_DZERO;
                    if (commit) begin
                        tag[lo] = TAG_NUM;
                        val[lo] = alu(t.cmd, a, b);
                        sp--;
                    end
                end
            endcase
            return ERR_OK;
        endfunction

        function logic [3:0] probe(token_t t);
            outcome_t r;
            if (halted) return ERR_HALT;
            return exec(t, 0, r);
        endfunction

        // Accepted request: advance the predictor and queue its outcome
        function void note_request(token_t t);
            outcome_t r;
            logic [3:0] e;
            e = halted ? ERR_HALT : exec(t, 1, r);
            if (e != ERR_OK) begin
                r = '0;
                r.err = e;
                halted = 1;
            end
            pending.push_back(r);
        endfunction

        function void check_outcome(outcome_t got);
            outcome_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result pv=%0d val=%0d br=%0d tgt=%0d err=%0d",
                             got.pvalid, $signed(got.pvalue), got.taken, got.btarget, got.err);
                return;
            end
            exp_r = pending.pop_front();
            if (got.pvalid !== exp_r.pvalid || got.pvalue !== exp_r.pvalue ||
                got.taken !== exp_r.taken || got.btarget !== exp_r.btarget ||
                got.err !== exp_r.err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp pv=%0d val=%0d br=%0d tgt=%0d err=%0d, got pv=%0d val=%0d br=%0d tgt=%0d err=%0d",
                             exp_r.pvalid, $signed(exp_r.pvalue), exp_r.taken,
                             exp_r.btarget, exp_r.err, got.pvalid,
                             $signed(got.pvalue), got.taken, got.btarget, got.err);
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [4:0]         i_command = '0;
    logic signed [15:0] i_literal = '0;
    logic [9:0]         i_var_address = '0;
    logic [4:0]         i_array_slot = '0;
    logic [15:0]        i_jump_target = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1;
    logic               o_print_valid;
    logic signed [15:0] o_print_value;
    logic               o_branch_taken;
    logic [15:0]        o_branch_target;
    logic [3:0]         o_error_code;

    token_scoreboard sb;
    token_t          macro_q[$];
    bit              quiet_phase;

    stack_token_machine i_dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (quiet_phase || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stall, sample at the rising edge
    initial begin
        outcome_t got;
        forever begin
            @(negedge i_clk);
            i_out_stall = (gap_len() != 0);
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.pvalid  = o_print_valid;
                got.pvalue  = o_print_value;
                got.taken   = o_branch_taken;
                got.btarget = o_branch_target;
                got.err     = o_error_code;
                sb.check_outcome(got);
            end
        end
    end

    // Request side: optional idle gap, then hold until accepted
    task send_token(token_t t);
        int g;
        g = gap_len();
        repeat (g) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_command     = t.cmd;
        i_literal     = t.lit;
        i_var_address = t.vaddr;
        i_array_slot  = t.slot;
        i_jump_target = t.target;
        i_in_valid    = 1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(t);
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    function token_t mk(logic [4:0] cmd, int lit = 0, int slot = 0, int tgt = 0, int va = 0);
        token_t t;
        t.cmd    = cmd;
        t.lit    = lit[15:0];
        t.vaddr  = va[9:0];
        t.slot   = slot[4:0];
        t.target = tgt[15:0];
        return t;
    endfunction

    function int rand_lit();
        if ($urandom_range(0, 1)) return $urandom_range(0, 24) - 4;
        return $urandom();
    endfunction

    // Short well-formed token sequences that exercise arrays and variables
    function void queue_sequence();
        int s;
        int v;
        s = $urandom_range(0, 31);
        v = $urandom_range(0, NVARS - 1);
        case ($urandom_range(0, 4))
            0: begin
                macro_q.push_back(mk(CMD_AREF, 0, s));
                macro_q.push_back(mk(CMD_LIT, ($urandom_range(0, 19) == 0) ?
                                     $urandom_range(0, 3000) : $urandom_range(0, 12)));
                macro_q.push_back(mk(CMD_ALLOC));
            end
            1: begin
                macro_q.push_back(mk(CMD_LIT, rand_lit()));
                macro_q.push_back(mk(CMD_AREF, 0, s));
                macro_q.push_back(mk(CMD_LIT, $urandom_range(0, 12)));
                macro_q.push_back(mk(CMD_INDEX));
                macro_q.push_back(mk(CMD_ASSIGN));
            end
            2: begin
                macro_q.push_back(mk(CMD_AREF, 0, s));
                macro_q.push_back(mk(CMD_LIT, $urandom_range(0, 12)));
                macro_q.push_back(mk(CMD_INDEX));
                macro_q.push_back(mk(CMD_PRINT));
            end
            3: begin
                macro_q.push_back(mk(CMD_LIT, rand_lit()));
                macro_q.push_back(mk(CMD_VREF, 0, 0, 0, v));
                macro_q.push_back(mk(CMD_ASSIGN));
                macro_q.push_back(mk(CMD_VREF, 0, 0, 0, v));
                macro_q.push_back(mk(CMD_PRINT));
            end
            default: begin
                macro_q.push_back(mk(CMD_WHILE));
                macro_q.push_back(mk(CMD_VREF, 0, 0, 0, v));
                macro_q.push_back(mk(CMD_DO, 0, 0, $urandom()));
                macro_q.push_back(mk(CMD_END, 0, 0, $urandom()));
            end
        endcase
    endfunction

    function token_t pick_token();
        token_t t;
        if (macro_q.size() == 0 && $urandom_range(0, 4) == 0) queue_sequence();
        if (macro_q.size() != 0) begin
            t = macro_q.pop_front();
        end else begin
            t.lit    = 16'(rand_lit());
            t.vaddr  = 10'($urandom());
            t.slot   = 5'($urandom());
            t.target = 16'($urandom());
            if (sb.sp < 100 && $urandom_range(0, 99) < 40)
                t.cmd = 5'($urandom_range(CMD_LIT, CMD_AREF));
            else
                t.cmd = 5'($urandom_range(CMD_ADD, CMD_ALLOC));
        end
        // keep the machine out of its halted state during the random part
        if (sb.probe(t) != ERR_OK) begin
            if (sb.sp >= 120) t.cmd = CMD_PRINT;
            else begin
                t.cmd = CMD_LIT;
                t.lit = 16'(rand_lit());
            end
        end
        return t;
    endfunction

    initial begin
        #20ms;
        $display("stack_token_machine_tb failed");
        $finish;
    end

    initial begin
        token_t dir_q[$];
        int     wait_cyc;
        int     n;
        sb = new();
        quiet_phase = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: field extremes, wrap, shift and branch corner cases
        dir_q = '{mk(CMD_LIT, 32767), mk(CMD_LIT, -32768), mk(CMD_SUB), mk(CMD_PRINT),
                  mk(CMD_LIT, -32768), mk(CMD_LIT, -1), mk(CMD_DIV), mk(CMD_PRINT),
                  mk(CMD_LIT, 5), mk(CMD_LIT, 40), mk(CMD_SHL), mk(CMD_PRINT),
                  mk(CMD_LIT, -8), mk(CMD_LIT, -3), mk(CMD_SHR), mk(CMD_PRINT),
                  mk(CMD_LIT, 0), mk(CMD_IF, 0, 0, 65535), mk(CMD_ELSE, 0, 0, 0),
                  mk(CMD_END, 0, 0, 0), mk(CMD_WHILE), mk(CMD_AREF, 0, 31),
                  mk(CMD_LIT, 3), mk(CMD_ALLOC), mk(CMD_END, 0, 0, 1234)};
        foreach (dir_q[i]) send_token(dir_q[i]);

        // Random well-formed traffic
        for (n = 0; n < RAND_REQS; n++) begin
            if (n % 200 == 100) quiet_phase = 1;
            if (n % 200 == 150) quiet_phase = 0;
            send_token(pick_token());
        end

        // One error to finish, then halted requests
        case ($urandom_range(0, 3))
            0: send_token(mk(5'd31));
            1: begin
                send_token(mk(CMD_LIT, rand_lit()));
                send_token(mk(CMD_LIT, 0));
                send_token(mk(CMD_MOD));
            end
            2: repeat (SDEPTH + 1) send_token(mk(CMD_LIT, rand_lit()));
            default: repeat (SDEPTH + 1) send_token(mk(CMD_PRINT));
        endcase
        repeat (5) send_token(mk(5'($urandom()), $urandom(), $urandom(), $urandom(),
                                 $urandom()));

        wait_cyc = 0;
        while (sb.pending.size() != 0 && wait_cyc < 20000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("stack_token_machine_tb passed");
        end else begin
            $display("stack_token_machine_tb failed");
        end
        $finish;
    end

endmodule
